@@ hdl/bmd_pkg.sv @@
// Shared types and constants for the binary mask dilation unit.
// No dependencies; compile first.
package bmd_pkg;

    // Default sizing of the line store and row window
    localparam int MAX_RADIUS_DEF = 15;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT     = 4096;

    // Field and register widths
    localparam int PIX_W      = 8;
    localparam int HGT_W      = 13;
    localparam int RAD_CFG_W  = 4;
    localparam int WID_CFG_W  = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD,
        ST_WRITE,
        ST_VSCAN,
        ST_VDRAIN,
        ST_HSTART,
        ST_HSETUP,
        ST_HSCAN,
        ST_EMIT,
        ST_ADV
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic mod_step;
        logic write;
        logic vinit;
        logic vscan;
        logic vdrain;
        logic hstart;
        logic hsetup;
        logic hscan;
        logic emit;
        logic next_ox;
        logic advance;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clamp;
        logic mod_done;
        logic do_out;
        logic do_emit;
        logic scan_last;
        logic out_free;
        logic last_ox;
    } t_status;

endpackage

@@ hdl/bmd_pix_if.sv @@
// Input pixel channel: valid/ready handshake with one 8-bit pixel.
// Depends on bmd_pkg.
interface bmd_pix_if;
    logic                      valid;
    logic                      ready;
    logic [bmd_pkg::PIX_W-1:0] pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface

@@ hdl/bmd_mask_if.sv @@
// Output mask channel: valid/ready handshake with dilated pixel and flags.
// Depends on bmd_pkg.
interface bmd_mask_if;
    logic                      valid;
    logic                      ready;
    logic [bmd_pkg::PIX_W-1:0] mask_value;
    logic                      last_of_run;
    logic                      end_of_frame;

    modport source (output valid, output mask_value, output last_of_run,
                    output end_of_frame, input ready);
    modport sink   (input valid, input mask_value, input last_of_run,
                    input end_of_frame, output ready);
endinterface

@@ hdl/bmd_ctrl.sv @@
// Sequencer for one pixel transaction: store, vertical scan, horizontal runs.
// Depends on bmd_pkg.
module bmd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  bmd_pkg::t_status  i_status,
    output bmd_pkg::t_cmd     o_cmd
);
    import bmd_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_status.clamp ? ST_MOD : ST_WRITE;
                end
            end
            ST_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_status.mod_done) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                o_cmd.write = 1'b1;
                o_cmd.vinit = 1'b1;
                n_state     = i_status.do_out ? ST_VSCAN : ST_ADV;
            end
            ST_VSCAN: begin
                o_cmd.vscan = 1'b1;
                if (i_status.scan_last) begin
                    n_state = ST_VDRAIN;
                end
            end
            ST_VDRAIN: begin
                o_cmd.vdrain = 1'b1;
                n_state      = i_status.do_emit ? ST_HSTART : ST_ADV;
            end
            ST_HSTART: begin
                o_cmd.hstart = 1'b1;
                n_state      = ST_HSETUP;
            end
            ST_HSETUP: begin
                o_cmd.hsetup = 1'b1;
                n_state      = ST_HSCAN;
            end
            ST_HSCAN: begin
                o_cmd.hscan = 1'b1;
                if (i_status.scan_last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // Hold until the output register is free
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.last_ox) begin
                        n_state = ST_ADV;
                    end else begin
                        o_cmd.next_ox = 1'b1;
                        n_state       = ST_HSETUP;
                    end
                end
            end
            ST_ADV: begin
                o_cmd.advance = 1'b1;
                n_state       = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/bmd_dp.sv @@
// Datapath: configuration, counters, line store, row window, output register.
// Depends on bmd_pkg; driven by bmd_ctrl commands.
module bmd_dp #(
    parameter int MAX_RADIUS = bmd_pkg::MAX_RADIUS_DEF,
    parameter int MAX_WIDTH  = bmd_pkg::MAX_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bmd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bmd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [bmd_pkg::PIX_W-1:0]      i_pix_value,
    input  bmd_pkg::t_cmd                  i_cmd,
    output bmd_pkg::t_status               o_status,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [bmd_pkg::PIX_W-1:0]      o_mask_value,
    output logic                           o_last_of_run,
    output logic                           o_end_of_frame
);
    import bmd_pkg::*;

    localparam int SLOTS = 2 * MAX_RADIUS + 1;
    localparam int SW    = $clog2(SLOTS);
    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int CW    = XW + SW + 2;
    localparam int HW    = HGT_W;
    localparam int WIDTH_RST = (512 > MAX_WIDTH) ? MAX_WIDTH : 512;

    // Slot arithmetic modulo the number of stored rows
    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
        logic [SW-1:0] res;
        res = (s == SW'(SLOTS - 1)) ? '0 : SW'(s + 1'b1);
        return res;
    endfunction

    function automatic logic [SW-1:0] slot_sub(input logic [SW-1:0] s,
                                               input logic [SW-1:0] k);
        logic [SW-1:0] res;
        res = (s >= k) ? SW'(s - k)
                       : SW'((SW+1)'(s) + (SW+1)'(SLOTS) - (SW+1)'(k));
        return res;
    endfunction

    // Configuration registers
    logic [RW-1:0] r_radius;
    logic [WW-1:0] r_width;
    logic [HW-1:0] r_height;

    // Stream position
    logic [HW-1:0] r_row;
    logic [XW-1:0] r_col;
    logic [SW-1:0] r_row_slot;
    logic [SW-1:0] r_col_slot;

    // Current transaction
    logic [PIX_W-1:0] r_pix;
    logic [XW-1:0]    r_x;
    logic [SW-1:0]    r_xslot;
    logic [XW-1:0]    r_mod;

    // Scans
    logic [SW-1:0]    r_left;
    logic [SW-1:0]    r_vslot;
    logic [PIX_W-1:0] r_vmax;
    logic             r_rd_vld;
    logic [PIX_W-1:0] r_rd_data;
    logic [XW-1:0]    r_ox;
    logic [XW-1:0]    r_last_ox;
    logic [XW-1:0]    r_clo;
    logic [SW-1:0]    r_clo_slot;
    logic [SW-1:0]    r_hslot;
    logic [PIX_W-1:0] r_hmax;

    // Storage
    logic [PIX_W-1:0] r_line [SLOTS][MAX_WIDTH];
    logic [PIX_W-1:0] r_win  [SLOTS];

    // Output register
    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_mask;
    logic             r_out_last;
    logic             r_out_eof;

    // Derived values
    logic [XW-1:0]    w_last;
    logic             col_clamp;
    logic [XW-1:0]    x_now;
    logic             row_end;
    logic             frame_end;
    logic             do_write;
    logic [HW-1:0]    rad_h;
    logic [HW-1:0]    oy;
    logic [HW-1:0]    v_lo;
    logic [HW-1:0]    v_hi;
    logic [SW-1:0]    v_start;
    logic [SW-1:0]    two_r;
    logic [XW-1:0]    first;
    logic             first_gt_r;
    logic [XW-1:0]    clo0;
    logic [SW-1:0]    cslot0;
    logic [CW-1:0]    ox_plus_r;
    logic [XW-1:0]    chi;
    logic [PIX_W-1:0] win_rd;
    logic [PIX_W-1:0] v_final;

    always_comb begin
        w_last     = XW'(r_width - 1'b1);
        col_clamp  = r_col > w_last;
        x_now      = col_clamp ? w_last : r_col;
        row_end    = (r_x == w_last);
        frame_end  = row_end &&
                     (((HW+1)'(r_row) + 1'b1) >= ((HW+1)'(r_height) + (HW+1)'(r_radius)));
        do_write   = r_row < r_height;
        rad_h      = HW'(r_radius);
        oy         = r_row - rad_h;
        v_lo       = (oy > rad_h) ? (oy - rad_h) : '0;
        v_hi       = do_write ? r_row : (r_height - 1'b1);
        v_start    = slot_sub(r_row_slot, SW'(r_row - v_hi));
        two_r      = SW'({r_radius, 1'b0});
        first      = (CW'(r_x) >= CW'(r_radius)) ? XW'(r_x - XW'(r_radius)) : '0;
        first_gt_r = CW'(first) > CW'(r_radius);
        clo0       = first_gt_r ? XW'(first - XW'(r_radius)) : '0;
        cslot0     = first_gt_r ? slot_sub(r_xslot, two_r) : '0;
        ox_plus_r  = CW'(r_ox) + CW'(r_radius);
        chi        = (ox_plus_r > CW'(w_last)) ? w_last : XW'(ox_plus_r);
        win_rd     = r_win[r_hslot];
        v_final    = (r_rd_data > r_vmax) ? r_rd_data : r_vmax;
    end

    // Status to the controller
    always_comb begin
        o_status.clamp     = col_clamp;
        o_status.mod_done  = CW'(r_mod) < CW'(SLOTS);
        o_status.do_out    = (r_row >= rad_h) && (oy < r_height);
        o_status.do_emit   = (CW'(r_x) >= CW'(r_radius)) || row_end;
        o_status.scan_last = (r_left == '0);
        o_status.out_free  = !r_out_valid || i_out_ready;
        o_status.last_ox   = (r_ox == r_last_ox);
    end

    // Configuration writes, saturated to the supported range
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RW'(1);
            r_width  <= WW'(WIDTH_RST);
            r_height <= HW'(512);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RADIUS: begin
                    r_radius <= (int'(i_cfg_data[RAD_CFG_W-1:0]) > MAX_RADIUS)
                              ? RW'(MAX_RADIUS) : RW'(i_cfg_data[RAD_CFG_W-1:0]);
                end
                CFG_WIDTH: begin
                    if (i_cfg_data[WID_CFG_W-1:0] == '0) begin
                        r_width <= WW'(1);
                    end else if (int'(i_cfg_data[WID_CFG_W-1:0]) > MAX_WIDTH) begin
                        r_width <= WW'(MAX_WIDTH);
                    end else begin
                        r_width <= WW'(i_cfg_data[WID_CFG_W-1:0]);
                    end
                end
                CFG_HEIGHT: begin
                    if (i_cfg_data[HW-1:0] == '0) begin
                        r_height <= HW'(1);
                    end else if (int'(i_cfg_data[HW-1:0]) > MAX_HEIGHT) begin
                        r_height <= HW'(MAX_HEIGHT);
                    end else begin
                        r_height <= i_cfg_data[HW-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Row and column counters, advanced once per transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= '0;
            r_col      <= '0;
            r_row_slot <= '0;
            r_col_slot <= '0;
        end else if (i_cmd.advance) begin
            if (row_end) begin
                r_col      <= '0;
                r_col_slot <= '0;
                if (frame_end) begin
                    r_row      <= '0;
                    r_row_slot <= '0;
                end else begin
                    r_row      <= r_row + 1'b1;
                    r_row_slot <= slot_inc(r_row_slot);
                end
            end else begin
                r_col      <= r_x + 1'b1;
                r_col_slot <= slot_inc(r_xslot);
            end
        end
    end

    // Latch the transaction; reduce a clamped column modulo the slot count
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pix   <= i_pix_value;
            r_x     <= x_now;
            r_xslot <= r_col_slot;
            r_mod   <= w_last;
        end else if (i_cmd.mod_step) begin
            if (CW'(r_mod) >= CW'(SLOTS)) begin
                r_mod <= XW'(CW'(r_mod) - CW'(SLOTS));
            end else begin
                r_xslot <= SW'(r_mod);
            end
        end
    end

    // Line store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.write && do_write) begin
            r_line[r_row_slot][r_x] <= r_pix;
        end
        r_rd_data <= r_line[r_vslot][r_x];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.vscan;
        end
    end

    // Scan counter and vertical maximum down the stored rows
    always_ff @(posedge i_clk) begin
        priority if (i_cmd.vinit) begin
            r_left  <= SW'(v_hi - v_lo);
            r_vslot <= v_start;
            r_vmax  <= '0;
        end else if (i_cmd.vscan) begin
            r_left  <= r_left - 1'b1;
            r_vslot <= (r_vslot == '0) ? SW'(SLOTS - 1) : SW'(r_vslot - 1'b1);
            if (r_rd_vld && (r_rd_data > r_vmax)) begin
                r_vmax <= r_rd_data;
            end
        end else if (i_cmd.hsetup) begin
            r_left  <= SW'(chi - r_clo);
        end else if (i_cmd.hscan) begin
            r_left  <= r_left - 1'b1;
        end
    end

    // Row window of column maxima
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_win[i] <= '0;
            end
        end else if (i_cmd.vdrain) begin
            r_win[r_xslot] <= v_final;
        end
    end

    // Horizontal run: output column, window start and running maximum
    always_ff @(posedge i_clk) begin
        if (i_cmd.hstart) begin
            r_ox       <= first;
            r_last_ox  <= row_end ? w_last : first;
            r_clo      <= clo0;
            r_clo_slot <= cslot0;
        end else if (i_cmd.next_ox) begin
            r_ox <= r_ox + 1'b1;
            if (CW'(r_ox) >= CW'(r_radius)) begin
                r_clo      <= r_clo + 1'b1;
                r_clo_slot <= slot_inc(r_clo_slot);
            end
        end
        if (i_cmd.hsetup) begin
            r_hslot <= r_clo_slot;
            r_hmax  <= '0;
        end else if (i_cmd.hscan) begin
            r_hslot <= slot_inc(r_hslot);
            if (win_rd > r_hmax) begin
                r_hmax <= win_rd;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_mask <= r_hmax;
            r_out_last <= (r_ox == r_last_ox);
            r_out_eof  <= (oy == (r_height - 1'b1)) && (r_ox == w_last);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_mask_value   = r_out_mask;
    assign o_last_of_run  = r_out_last;
    assign o_end_of_frame = r_out_eof;

endmodule

@@ hdl/binary_mask_dilation_unit.sv @@
// Top level of the binary mask dilation unit: controller plus datapath.
// Depends on bmd_pkg, bmd_pix_if, bmd_mask_if, bmd_ctrl and bmd_dp.
//
//  channel   | dir | handshake       | payload
//  ----------+-----+-----------------+------------------------------------------
//  i_pix     | in  | valid / ready   | pixel_value[7:0]
//  o_mask    | out | valid / ready   | mask_value[7:0], last_of_run, end_of_frame
//  i_cfg_*   | in  | i_cfg_we only   | i_cfg_idx (0 radius, 1 width, 2 height)
//
// One pixel at a time. An item outside the output rows is stored in the line
// store; one in an output row takes a vertical scan of the stored rows in the
// window (one memory read per cycle) and a drain into the row window, and if it
// gives results, a horizontal scan of the window columns for each result. For a
// clamped column the slot is found by repeated subtraction of 2*MAX_RADIUS+1
// from frame_width-1. Reset is synchronous; no clearing pass.
// The last result waits in an output register while the next pixel is taken;
// a stalled output holds the sequencer in its emit step.
module binary_mask_dilation_unit #(
    parameter int MAX_RADIUS = bmd_pkg::MAX_RADIUS_DEF,
    parameter int MAX_WIDTH  = bmd_pkg::MAX_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    bmd_pix_if.sink                        i_pix,
    bmd_mask_if.source                     o_mask,
    input  logic                           i_cfg_we,
    input  logic [bmd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bmd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bmd_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    in_ready;

    // Sequencer
    bmd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Datapath
    bmd_dp #(
        .MAX_RADIUS (MAX_RADIUS),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_pix_value    (i_pix.pixel_value),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_out_valid    (o_mask.valid),
        .i_out_ready    (o_mask.ready),
        .o_mask_value   (o_mask.mask_value),
        .o_last_of_run  (o_mask.last_of_run),
        .o_end_of_frame (o_mask.end_of_frame)
    );

    assign i_pix.ready = in_ready;

endmodule

@@ hdl/bmd_checker.sv @@
// Port-level checks for binary_mask_dilation_unit, attached with bind.
// Depends on bmd_pkg and the top level's port list.
module bmd_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [bmd_pkg::PIX_W-1:0] i_out_mask,
    input logic                      i_out_last,
    input logic                      i_out_eof
);
    import bmd_pkg::*;

    // Reset empties the output register
    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // Only one pixel is in work: input closes after each transaction
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input accepted twice in a row");

    // Frame end falls on the final result of its run
    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_eof) |-> i_out_last)
        else $error("end of frame without end of run");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_mask) && $stable(i_out_last)
             && $stable(i_out_eof)))
        else $error("stalled result changed");

endmodule

bind binary_mask_dilation_unit bmd_checker u_bmd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_mask.valid),
    .i_out_ready (o_mask.ready),
    .i_out_mask  (o_mask.mask_value),
    .i_out_last  (o_mask.last_of_run),
    .i_out_eof   (o_mask.end_of_frame)
);
